[rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int BUF_BYTES = 64;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int FILL_W    = $clog2(BUF_BYTES + 1);
    localparam int REM_W     = 16;
    localparam int PH_W      = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'h86;
    localparam logic [7:0] SYNC_SECOND = 8'hAB;
    localparam logic [7:0] HEADER_TAKE = 8'd4;
    localparam logic [7:0] TAIL_LEFT   = 8'd3;

    // step codes; receive steps follow the frame layout, replay steps come after
    localparam logic [PH_W-1:0] PH_HUNT    = 4'd0;
    localparam logic [PH_W-1:0] PH_SYNC2   = 4'd1;
    localparam logic [PH_W-1:0] PH_SIZE_HI = 4'd2;
    localparam logic [PH_W-1:0] PH_SIZE_LO = 4'd3;
    localparam logic [PH_W-1:0] PH_CMD1    = 4'd4;
    localparam logic [PH_W-1:0] PH_CMD2    = 4'd5;
    localparam logic [PH_W-1:0] PH_FUNC    = 4'd6;
    localparam logic [PH_W-1:0] PH_DATA    = 4'd7;
    localparam logic [PH_W-1:0] PH_NUM     = 4'd8;
    localparam logic [PH_W-1:0] PH_SUM     = 4'd9;
    localparam logic [PH_W-1:0] PH_END     = 4'd10;
    localparam logic [PH_W-1:0] PH_RP_RD   = 4'd11;
    localparam logic [PH_W-1:0] PH_RP_WR   = 4'd12;

    localparam logic [1:0] COND_NONE  = 2'd0;
    localparam logic [1:0] COND_SYNC1 = 2'd1;
    localparam logic [1:0] COND_SYNC2 = 2'd2;

    localparam logic [2:0] REM_HOLD  = 3'd0;
    localparam logic [2:0] REM_CLEAR = 3'd1;
    localparam logic [2:0] REM_HIGH  = 3'd2;
    localparam logic [2:0] REM_LOW   = 3'd3;
    localparam logic [2:0] REM_DEC   = 3'd4;

    typedef struct packed {
        logic            take;
        logic [1:0]      cond;
        logic            clr_frame;
        logic            store;
        logic            add_sum;
        logic [2:0]      rem_op;
        logic            emit_app;
        logic            save_chk;
        logic            chk_end;
        logic            tail_jump;
        logic [PH_W-1:0] next_ph;
        logic [PH_W-1:0] tail_ph;
        logic            rp_read;
        logic            rp_emit;
    } uword_t;

    // gated actions, sequencer to datapath
    typedef struct packed {
        logic       abort;
        logic       clr_frame;
        logic       store;
        logic       add_sum;
        logic [2:0] rem_op;
        logic       emit_app;
        logic       save_chk;
        logic       rp_start;
        logic       rp_read;
        logic       rp_emit;
    } act_t;

    // datapath flags, datapath to sequencer
    typedef struct packed {
        logic full;
        logic sync1_hit;
        logic sync2_hit;
        logic tail_hit;
        logic chk_pass;
        logic rp_last;
        logic out_free;
    } status_t;

    function automatic uword_t ucode(input logic [PH_W-1:0] ph);
        uword_t w;
        begin
            w = '0;
            unique case (ph)
                PH_SYNC2:
                begin
                    w.take = 1'b1; w.cond = COND_SYNC2; w.store = 1'b1;
                    w.add_sum = 1'b1; w.rem_op = REM_CLEAR; w.next_ph = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_HIGH; w.next_ph = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_LOW; w.next_ph = PH_CMD1;
                end
                PH_CMD1:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_DEC; w.next_ph = PH_CMD2;
                end
                PH_CMD2:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_DEC; w.next_ph = PH_FUNC;
                end
                PH_FUNC:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_DEC; w.emit_app = 1'b1; w.tail_jump = 1'b1;
                    w.next_ph = PH_DATA; w.tail_ph = PH_NUM;
                end
                PH_DATA:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_DEC; w.tail_jump = 1'b1;
                    w.next_ph = PH_DATA; w.tail_ph = PH_NUM;
                end
                PH_NUM:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.add_sum = 1'b1;
                    w.rem_op = REM_DEC; w.next_ph = PH_SUM;
                end
                PH_SUM:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.rem_op = REM_DEC;
                    w.save_chk = 1'b1; w.next_ph = PH_END;
                end
                PH_END:
                begin
                    w.take = 1'b1; w.store = 1'b1; w.rem_op = REM_DEC;
                    w.chk_end = 1'b1; w.next_ph = PH_HUNT;
                end
                PH_RP_RD:
                begin
                    w.rp_read = 1'b1; w.next_ph = PH_RP_WR;
                end
                PH_RP_WR:
                begin
                    w.rp_emit = 1'b1; w.next_ph = PH_RP_RD;
                end
                default:
                begin
                    // hunt, also for the unused codes
                    w.take = 1'b1; w.cond = COND_SYNC1; w.clr_frame = 1'b1;
                    w.store = 1'b1; w.add_sum = 1'b1; w.next_ph = PH_SYNC2;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/fpr_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpr_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fpr_pkg::status_t st,
    output fpr_pkg::act_t         act
);
    import fpr_pkg::*;

    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic [PH_W-1:0] ph_eff;
    uword_t          uw_raw;
    uword_t          uw;
    logic            fire;
    logic            cond_ok;
    logic            step;

    always_comb
    begin
        uw_raw = ucode(phase_reg);
        // a full buffer throws the frame away; the byte is then handled as a hunt byte
        ph_eff = (uw_raw.take && st.full) ? PH_HUNT : phase_reg;
        uw     = ucode(ph_eff);
    end

    assign in_ready = uw.take && st.out_free;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        case (uw.cond)
            COND_SYNC1: cond_ok = st.sync1_hit;
            COND_SYNC2: cond_ok = st.sync2_hit;
            default:    cond_ok = 1'b1;
        endcase
    end

    assign step = fire && cond_ok;

    always_comb
    begin
        act.abort     = fire && uw_raw.take && st.full;
        act.clr_frame = step && uw.clr_frame;
        act.store     = step && uw.store;
        act.add_sum   = step && uw.add_sum;
        act.rem_op    = step ? uw.rem_op : REM_HOLD;
        act.emit_app  = step && uw.emit_app;
        act.save_chk  = step && uw.save_chk;
        act.rp_start  = step && uw.chk_end && st.chk_pass;
        act.rp_read   = uw.rp_read;
        act.rp_emit   = uw.rp_emit && st.out_free;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (!cond_ok)
                phase_next = PH_HUNT;
            else if (uw.tail_jump && st.tail_hit)
                phase_next = uw.tail_ph;
            else if (act.rp_start)
                phase_next = PH_RP_RD;
            else
                phase_next = uw.next_ph;
        end
        else if (uw.rp_read)
            phase_next = uw.next_ph;
        else if (act.rp_emit)
            phase_next = st.rp_last ? PH_HUNT : uw.next_ph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_HUNT;
        else
            phase_reg <= phase_next;
    end

endmodule

`default_nettype wire

[rtl/fpr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpr_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [7:0]                  rx_byte,
    input  wire fpr_pkg::act_t               act,
    output fpr_pkg::status_t                 st,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             kind,
    output logic [7:0]                       value,
    output logic [fpr_pkg::FILL_W-1:0]       frame_length,
    output logic                             last
);
    import fpr_pkg::*;

    logic [7:0]        mem [BUF_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_base;
    logic [REM_W-1:0]  remaining_reg;
    logic [REM_W-1:0]  remaining_next;
    logic [7:0]        sum_reg;
    logic [7:0]        sum_next;
    logic [7:0]        chk_reg;
    logic [ADDR_W-1:0] rp_idx_reg;
    logic [ADDR_W-1:0] rp_idx_next;
    logic [7:0]        rd_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_load;
    logic              kind_reg;
    logic [7:0]        value_reg;
    logic [FILL_W-1:0] len_reg;
    logic              last_reg;

    always_comb
    begin
        fill_base = (act.abort || act.clr_frame) ? '0 : fill_reg;
        fill_next = act.store ? fill_base + 1'b1 : fill_base;

        sum_next = sum_reg;
        if (act.clr_frame)
            sum_next = '0;
        if (act.add_sum)
            sum_next = sum_next + rx_byte;

        case (act.rem_op)
            REM_CLEAR: remaining_next = '0;
            REM_HIGH:  remaining_next = {rx_byte, 8'h00};
            REM_LOW:   remaining_next = {remaining_reg[REM_W-1:8], remaining_reg[7:0] | rx_byte}
                                        - REM_W'(HEADER_TAKE);
            REM_DEC:   remaining_next = remaining_reg - 1'b1;
            default:   remaining_next = remaining_reg;
        endcase

        rp_idx_next = rp_idx_reg;
        if (act.rp_start)
            rp_idx_next = '0;
        else if (act.rp_emit)
            rp_idx_next = rp_idx_reg + 1'b1;
    end

    always_comb
    begin
        st.full      = (fill_reg == FILL_W'(BUF_BYTES));
        st.sync1_hit = (rx_byte == SYNC_FIRST);
        st.sync2_hit = (rx_byte == SYNC_SECOND);
        // countdown lands on the tail value after this byte's decrement
        st.tail_hit  = (remaining_reg == REM_W'(TAIL_LEFT) + 1'b1);
        st.chk_pass  = (remaining_reg == REM_W'(1)) && (chk_reg == sum_reg);
        st.rp_last   = ({1'b0, rp_idx_reg} + 1'b1 == fill_reg);
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign out_load       = act.emit_app || act.rp_emit;
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            rp_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            rp_idx_reg    <= rp_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.store)
            mem[fill_base[ADDR_W-1:0]] <= rx_byte;
        if (act.rp_read)
            rd_data_reg <= mem[rp_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (act.save_chk)
            chk_reg <= rx_byte;
        if (act.emit_app)
        begin
            kind_reg  <= 1'b0;
            value_reg <= rx_byte;
            len_reg   <= '0;
            last_reg  <= 1'b1;
        end
        else if (act.rp_emit)
        begin
            kind_reg  <= 1'b1;
            value_reg <= rd_data_reg;
            len_reg   <= fill_reg;
            last_reg  <= st.rp_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign frame_length = len_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[rtl/framed_packet_receiver_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake              payload
// in       in_valid / in_ready    rx_byte
// out      out_valid / out_ready  kind, value, frame_length, last
//
// A received byte is accepted when the sequencer is in a receive step and the output register is free.
// Replaying an accepted frame runs two steps per byte: a buffer read step, then an
// output load step; input is held off until the frame's last byte has been loaded.
// The output register stalls the replay sequencer while it holds a byte and out_ready is low.
// Reset clears the step counter, counters and output valid; the buffer is not cleared.

module framed_packet_receiver_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             kind,
    output logic [7:0]                       value,
    output logic [fpr_pkg::FILL_W-1:0]       frame_length,
    output logic                             last
);
    import fpr_pkg::*;

    act_t    act;
    status_t st;

    fpr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .act      (act)
    );

    fpr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .act          (act),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value        (value),
        .frame_length (frame_length),
        .last         (last)
    );

endmodule

`default_nettype wire

[rtl/fpr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpr_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        kind,
    input wire logic [7:0]                  value,
    input wire logic [fpr_pkg::FILL_W-1:0]  frame_length,
    input wire logic                        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && $stable(kind) && $stable(last))
        else $error("output payload changed while stalled");

    a_app_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> last && (frame_length == '0))
        else $error("app select with bad length or last");

    // mid-replay, no new byte may enter
    a_replay_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind && !last |-> !in_ready || !in_valid)
        else $error("input taken during frame replay");

endmodule

bind framed_packet_receiver_unit fpr_checker u_fpr_checker (.*);

`default_nettype wire
